[src/epse_pkg.sv]
// Shared types and constants for the encoder position / speed estimator.
// Used by the remainder unit, datapath, controller and top level.
package epse_pkg;

  // serial remainder unit sizing
  localparam int DIV_W  = 24;
  localparam int REM_W  = 17;
  localparam int STEP_W = 5;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 144;

  localparam logic [REM_W-1:0] MOD_FULL  = 17'h10000;
  localparam logic [16:0]      ALPHA_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION      = 3'd0,
    CFG_DELTA_LIMIT    = 3'd1,
    CFG_WINDOW_TICKS   = 3'd2,
    CFG_RPM_SCALE      = 3'd3,
    CFG_CONTROL_ALPHA  = 3'd4,
    CFG_DISPLAY_ALPHA  = 3'd5,
    CFG_COUNTS_PER_REV = 3'd6,
    CFG_POLE_PAIRS     = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DELTA,
    OP_ACCUM,
    OP_POS_START,
    OP_POS_FIX,
    OP_ELEC_START,
    OP_ELEC_FIX,
    OP_RAW_MUL,
    OP_RAW_FIN,
    OP_CTL_MUL,
    OP_CTL_FIN,
    OP_DSP_MUL,
    OP_DSP_FIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic rem_done;
    logic closed;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_ACCUM,
    S_POS_START,
    S_POS_WAIT,
    S_ELEC_START,
    S_ELEC_WAIT,
    S_RAW_MUL,
    S_RAW_FIN,
    S_CTL_MUL,
    S_CTL_FIN,
    S_DSP_MUL,
    S_DSP_FIN,
    S_DONE
  } ctrl_state_t;

endpackage

[src/epse_rem.sv]
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on epse_pkg for widths.
module epse_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [epse_pkg::DIV_W-1:0] dividend,
  input  logic [epse_pkg::REM_W-1:0] divisor,
  output logic                       done,
  output logic [epse_pkg::REM_W-1:0] remainder
);
  import epse_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W:0]    shifted;
  logic [REM_W:0]    trial;

  assign shifted = {rem_r, dvd_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      // partial remainder always stays below the divisor
      rem_r <= (shifted >= {1'b0, divisor}) ? trial[REM_W-1:0] : shifted[REM_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[src/epse_dp.sv]
// Datapath: config registers, delta/position logic, window sum, shared
// multiplier and remainder unit. Depends on epse_pkg and epse_rem.
module epse_dp #(
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [epse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epse_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [epse_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  epse_pkg::dp_op_t                 op,
  output epse_pkg::dp_status_t             status,
  output logic [epse_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser
);
  import epse_pkg::*;

  // configuration
  logic        dir_r;
  logic [14:0] lim_r;
  logic [15:0] wticks_r;
  logic [31:0] scale_r;
  logic [16:0] calpha_r;
  logic [16:0] dalpha_r;
  logic [15:0] cpr_r;
  logic [6:0]  pp_r;

  // item and state
  logic                   cmd_r;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic signed [16:0]     off_r;
  logic [COUNT_BITS-1:0]  prev_r;
  logic                   seen_r;
  logic [15:0]            rotor_r;
  logic signed [15:0]     delta_r;
  logic signed [31:0]     sum_r;
  logic signed [31:0]     samp_r;
  logic [15:0]            wcnt_r;
  logic                   close_r;
  logic                   neg_r;
  logic [DIV_W-1:0]       vmag_r;
  logic                   ctl_seed_r;
  logic                   dsp_seed_r;
  logic signed [31:0]     raw_r;
  logic signed [31:0]     ctl_r;
  logic signed [31:0]     dsp_r;
  logic [64:0]            prod_r;
  logic                   psign_r;
  logic [15:0]            elec_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  logic [31:0]           tc32;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [REM_W-1:0]      mod_w;

  assign tc32   = {16'd0, in_tdata[15:0]};
  assign cnt_in = tc32[COUNT_BITS-1:0];
  assign mod_w  = (cpr_r == 16'd0) ? MOD_FULL : {1'b0, cpr_r};

  // wrapped delta, clamp, direction
  logic [COUNT_BITS-1:0]        prev_eff;
  logic [COUNT_BITS-1:0]        d_raw;
  logic signed [COUNT_BITS-1:0] d_s;
  logic signed [32:0]           d_x;
  logic signed [32:0]           lim_x;
  logic signed [32:0]           d_cl;
  logic signed [15:0]           d_dir;

  assign prev_eff = seen_r ? prev_r : cnt_r;
  assign d_raw    = cnt_r - prev_eff;
  assign d_s      = signed'(d_raw);
  assign d_x      = 33'(d_s);
  assign lim_x    = signed'({18'd0, lim_r});
  assign d_cl     = (d_x > lim_x) ? lim_x : ((d_x < -lim_x) ? -lim_x : d_x);
  assign d_dir    = dir_r ? 16'(-d_cl) : d_cl[15:0];

  // window sum with saturation
  logic signed [32:0] s_x;
  logic signed [31:0] s_sat;
  logic [16:0]        wn;
  logic               win_end;

  assign s_x     = 33'(sum_r) + 33'(delta_r);
  assign s_sat   = (s_x[32] != s_x[31]) ? (s_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : s_x[31:0];
  assign wn      = {1'b0, wcnt_r} + 17'd1;
  assign win_end = (wn >= {1'b0, wticks_r});

  // position before reduction
  logic [31:0]        cnt32;
  logic [15:0]        cnt16;
  logic signed [18:0] sc_x;
  logic signed [18:0] off_x;
  logic signed [18:0] v;
  logic [18:0]        v_abs;

  assign cnt32 = 32'(cnt_r);
  assign cnt16 = cnt32[15:0];
  assign sc_x  = dir_r ? -signed'({3'd0, cnt16}) : signed'({3'd0, cnt16});
  assign off_x = 19'(off_r);
  assign v     = cmd_r ? (sc_x - off_x) : (signed'({3'd0, rotor_r}) + 19'(delta_r));
  assign v_abs = v[18] ? 19'(-v) : 19'(v);

  // remainder unit
  logic [22:0]      elec_prod;
  logic             rem_start;
  logic [DIV_W-1:0] rem_dvd;
  logic             rem_done;
  logic [REM_W-1:0] rem_val;

  assign elec_prod = 23'(rotor_r) * 23'(pp_r);
  assign rem_start = (op == OP_POS_START) || (op == OP_ELEC_START);
  assign rem_dvd   = (op == OP_ELEC_START) ? DIV_W'(elec_prod) : vmag_r;

  epse_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_dvd),
    .divisor   (mod_w),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // shared multiplier operands, magnitudes only
  logic               ema_ctl;
  logic signed [31:0] ema_cur;
  logic [16:0]        ema_alpha;
  logic [16:0]        alpha_cl;
  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic signed [32:0] samp_x;
  logic [32:0]        samp_abs;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;

  assign ema_ctl   = (op == OP_CTL_MUL) || (op == OP_CTL_FIN);
  assign ema_cur   = ema_ctl ? ctl_r : dsp_r;
  assign ema_alpha = ema_ctl ? calpha_r : dalpha_r;
  assign alpha_cl  = (ema_alpha > ALPHA_ONE) ? ALPHA_ONE : ema_alpha;
  assign diff      = 33'(raw_r) - 33'(ema_cur);
  assign diff_abs  = diff[32] ? 33'(-diff) : 33'(diff);
  assign samp_x    = 33'(samp_r);
  assign samp_abs  = samp_x[32] ? 33'(-samp_x) : 33'(samp_x);

  always_comb begin
    case (op)
      OP_RAW_MUL: begin
        mul_a   = samp_abs;
        mul_b   = scale_r;
        mul_neg = samp_r[31];
      end
      default: begin
        mul_a   = diff_abs;
        mul_b   = 32'(alpha_cl);
        mul_neg = diff[32];
      end
    endcase
  end

  // rounding half away from zero on the magnitude, then sign; raw speed also saturates
  logic [64:0]        raw_sum;
  logic [56:0]        q_raw;
  logic signed [31:0] raw_new;
  logic [64:0]        ema_sum;
  logic [33:0]        q_ema;
  logic signed [33:0] q_s;
  logic signed [31:0] ema_new;

  assign raw_sum = prod_r + 65'd128;
  assign q_raw   = raw_sum[64:8];
  assign raw_new = !psign_r ? ((q_raw > 57'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_raw[31:0])
                            : ((q_raw > 57'h8000_0000) ? 32'h8000_0000 : 32'(-q_raw));
  assign ema_sum = prod_r + 65'd32768;
  assign q_ema   = ema_sum[49:16];
  assign q_s     = psign_r ? -signed'(q_ema) : signed'(q_ema);
  assign ema_new = 32'(34'(ema_cur) + q_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      lim_r    <= 15'd32767;
      wticks_r <= 16'd100;
      scale_r  <= 32'd65536;
      calpha_r <= 17'd65536;
      dalpha_r <= 17'd3277;
      cpr_r    <= 16'd4000;
      pp_r     <= 7'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIRECTION:      dir_r    <= cfg_data[0];
        CFG_DELTA_LIMIT:    lim_r    <= cfg_data[14:0];
        CFG_WINDOW_TICKS:   wticks_r <= cfg_data[15:0];
        CFG_RPM_SCALE:      scale_r  <= cfg_data;
        CFG_CONTROL_ALPHA:  calpha_r <= cfg_data[16:0];
        CFG_DISPLAY_ALPHA:  dalpha_r <= cfg_data[16:0];
        CFG_COUNTS_PER_REV: cpr_r    <= cfg_data[15:0];
        CFG_POLE_PAIRS:     pp_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      seen_r     <= 1'b0;
      rotor_r    <= '0;
      sum_r      <= '0;
      wcnt_r     <= '0;
      ctl_seed_r <= 1'b0;
      dsp_seed_r <= 1'b0;
      raw_r      <= '0;
      ctl_r      <= '0;
      dsp_r      <= '0;
    end else begin
      case (op)
        OP_DELTA: begin
          prev_r <= cnt_r;
          seen_r <= 1'b1;
          if (cmd_r) begin
            sum_r      <= '0;
            wcnt_r     <= '0;
            ctl_seed_r <= 1'b0;
            dsp_seed_r <= 1'b0;
            raw_r      <= '0;
            ctl_r      <= '0;
            dsp_r      <= '0;
          end
        end
        OP_ACCUM: begin
          if (!cmd_r) begin
            if (win_end) begin
              sum_r  <= '0;
              wcnt_r <= '0;
            end else begin
              sum_r  <= s_sat;
              wcnt_r <= wn[15:0];
            end
          end
        end
        OP_POS_FIX: begin
          rotor_r <= (neg_r && rem_val != '0) ? 16'(mod_w - rem_val) : rem_val[15:0];
        end
        OP_RAW_FIN: raw_r <= raw_new;
        OP_CTL_FIN: begin
          ctl_r      <= ctl_seed_r ? ema_new : raw_r;
          ctl_seed_r <= 1'b1;
        end
        OP_DSP_FIN: begin
          dsp_r      <= dsp_seed_r ? ema_new : raw_r;
          dsp_seed_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op) inside
      OP_LOAD: begin
        cmd_r <= in_tuser;
        cnt_r <= cnt_in;
        off_r <= signed'(in_tdata[32:16]);
      end
      OP_DELTA: begin
        delta_r <= cmd_r ? 16'sd0 : d_dir;
        close_r <= 1'b0;
      end
      OP_ACCUM: begin
        neg_r  <= v[18];
        vmag_r <= DIV_W'(v_abs);
        if (!cmd_r && win_end) begin
          samp_r  <= s_sat;
          close_r <= 1'b1;
        end
      end
      OP_ELEC_FIX: elec_r <= rem_val[15:0];
      OP_RAW_MUL, OP_CTL_MUL, OP_DSP_MUL: begin
        prod_r  <= 65'(mul_a) * 65'(mul_b);
        psign_r <= mul_neg;
      end
      OP_OUT: begin
        out_tdata_r <= {dsp_r, ctl_r, raw_r, delta_r, elec_r, rotor_r};
        out_tuser_r <= close_r;
      end
      default: ;
    endcase
  end

  assign status.rem_done = rem_done;
  assign status.closed   = close_r;
  assign out_tdata       = out_tdata_r;
  assign out_tuser       = out_tuser_r;

endmodule

[src/epse_ctrl.sv]
// Controller: sequences one item through the datapath and owns the output
// valid flag. Depends on epse_pkg.
module epse_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  epse_pkg::dp_status_t status,
  output epse_pkg::dp_op_t     op
);
  import epse_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        op        = OP_DELTA;
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        op        = OP_ACCUM;
        state_nxt = S_POS_START;
      end
      S_POS_START: begin
        op        = OP_POS_START;
        state_nxt = S_POS_WAIT;
      end
      S_POS_WAIT: begin
        if (status.rem_done) begin
          op        = OP_POS_FIX;
          state_nxt = S_ELEC_START;
        end
      end
      S_ELEC_START: begin
        op        = OP_ELEC_START;
        state_nxt = S_ELEC_WAIT;
      end
      S_ELEC_WAIT: begin
        if (status.rem_done) begin
          op        = OP_ELEC_FIX;
          state_nxt = status.closed ? S_RAW_MUL : S_DONE;
        end
      end
      S_RAW_MUL: begin
        op        = OP_RAW_MUL;
        state_nxt = S_RAW_FIN;
      end
      S_RAW_FIN: begin
        op        = OP_RAW_FIN;
        state_nxt = S_CTL_MUL;
      end
      S_CTL_MUL: begin
        op        = OP_CTL_MUL;
        state_nxt = S_CTL_FIN;
      end
      S_CTL_FIN: begin
        op        = OP_CTL_FIN;
        state_nxt = S_DSP_MUL;
      end
      S_DSP_MUL: begin
        op        = OP_DSP_MUL;
        state_nxt = S_DSP_FIN;
      end
      S_DSP_FIN: begin
        op        = OP_DSP_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait here only while the output register still holds an untaken beat
        if (!out_valid_r || out_tready) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[src/encoder_position_speed_estimator_top.sv]
// Encoder position and speed estimator, top level.
// Input channel (in_*): one beat per item. in_tuser is the command, 0 = tick
//   with a new timer count, 1 = start and align the position.
// Output channel (out_*): one beat per input item with position, electrical
//   angle, step delta and the three speed values; out_tuser flags that the
//   item closed a speed window.
// Config channel (cfg_*): cfg_index selects one of eight registers, always
//   ready; write only while no item is in flight.
// Sequencing: an item runs from acceptance to its output beat through two
//   passes of the 24-step serial remainder unit (position modulo
//   counts_per_rev, then electrical angle); a window close adds six
//   multiply/round steps.
// One item is in flight at a time; in_tready is high only while idle.
// Results sit in an output register, so the next item is accepted while the
//   previous beat waits; a finished item stalls only if that beat is not
//   yet taken.
// Reset (rst_n, synchronous, active low) restores the register defaults and
//   clears position, window and filter state.
module encoder_position_speed_estimator_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] timer_count, [32:16] align_offset, [39:33] zero
  input  logic [epse_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] mech_position, [31:16] elec_position, [47:32] step_delta,
  // [79:48] raw_speed_q8, [111:80] control_speed_q8, [143:112] display_speed_q8
  output logic [epse_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] sample_ready
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [epse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epse_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import epse_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  epse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .op         (op)
  );

  epse_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .op        (op),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

[tb/speed_estimator_checker.sv]
// Scoreboard for the encoder position / speed estimator: mirrors the register
// file and the position, window and filter state, predicts each output beat.
// Depends on epse_pkg for channel widths and register indexes.
module speed_estimator_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // [15:0] timer_count, [32:16] align_offset, [39:33] zero
  input  logic [epse_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] command, high for a start beat
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] mech, [31:16] elec, [47:32] delta, [79:48] raw, [111:80] control,
  // [143:112] display
  input  logic [epse_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] sample_ready
  input  logic                             out_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [epse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epse_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               windows_closed
);
  import epse_pkg::*;

  typedef struct packed {
    logic [15:0] mech;
    logic [15:0] elec;
    logic [15:0] delta;
    logic        ready;
    logic [31:0] raw;
    logic [31:0] control;
    logic [31:0] display;
  } estimate_t;

  localparam longint I32_MAX     = 64'sd2147483647;
  localparam longint I32_MIN     = -64'sd2147483648;

  // register mirror
  logic        dir_neg;
  logic [14:0] delta_lim;
  logic [15:0] win_ticks;
  logic [31:0] rpm_scale;
  logic [16:0] ctl_alpha;
  logic [16:0] dsp_alpha;
  logic [15:0] counts_rev;
  logic [6:0]  poles;

  // estimator state
  logic [15:0] last_count;
  logic        count_valid;
  logic [15:0] rotor;
  int          win_sum;
  int          win_count;
  logic        ctl_seeded;
  logic        dsp_seeded;
  int          ctl_speed;
  int          dsp_speed;
  int          raw_speed;

  estimate_t   pending_estimates[$];
  estimate_t   oldest;
  int          out_beats;

  function automatic logic [15:0] wrap_mod(longint v, longint m);
    longint r;
    r = v % m;
    if (r < 0) r += m;
    return r[15:0];
  endfunction

  // divide by 2^sh, ties away from zero
  function automatic longint round_half_away(longint p, int sh);
    longint unsigned mag;
    longint unsigned q;
    mag = (p < 0) ? longint'(-p) : p;
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int sat_i32(longint v);
    if (v > I32_MAX) return int'(I32_MAX);
    if (v < I32_MIN) return int'(I32_MIN);
    return int'(v);
  endfunction

  function automatic int ema_step(int cur, int target, logic [16:0] alpha);
    longint diff;
    longint w;
    diff = longint'(target) - longint'(cur);
    w = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
    return int'(longint'(cur) + round_half_away(diff * w, 16));
  endfunction

  task automatic predict_estimate(logic start, logic [15:0] count, logic [16:0] offset);
    longint    m;
    longint    delta;
    longint    lim;
    longint    acc;
    logic [15:0] diff16;
    logic      closed;
    estimate_t est;
    m = (counts_rev == 0) ? longint'(MOD_FULL) : longint'(counts_rev);
    delta = 0;
    closed = 1'b0;
    if (start) begin
      acc = dir_neg ? -longint'(count) : longint'(count);
      win_sum = 0;
      win_count = 0;
      ctl_seeded = 1'b0;
      dsp_seeded = 1'b0;
      ctl_speed = 0;
      dsp_speed = 0;
      raw_speed = 0;
      rotor = wrap_mod(acc - longint'($signed(offset)), m);
      last_count = count;
      count_valid = 1'b1;
    end else begin
      // very first count only seeds the history
      if (!count_valid) begin
        last_count = count;
        count_valid = 1'b1;
      end
      diff16 = count - last_count;
      delta = longint'($signed(diff16));
      last_count = count;
      lim = longint'(delta_lim);
      if (delta > lim) delta = lim;
      if (delta < -lim) delta = -lim;
      if (dir_neg) delta = -delta;
      rotor = wrap_mod(longint'(rotor) + delta, m);
      win_sum = sat_i32(longint'(win_sum) + delta);
      win_count++;
      if (win_count >= win_ticks) begin
        raw_speed = sat_i32(round_half_away(longint'(win_sum) * longint'(rpm_scale), 8));
        ctl_speed = ctl_seeded ? ema_step(ctl_speed, raw_speed, ctl_alpha) : raw_speed;
        dsp_speed = dsp_seeded ? ema_step(dsp_speed, raw_speed, dsp_alpha) : raw_speed;
        ctl_seeded = 1'b1;
        dsp_seeded = 1'b1;
        win_sum = 0;
        win_count = 0;
        closed = 1'b1;
        windows_closed++;
      end
    end
    est.mech    = rotor;
    est.elec    = wrap_mod(longint'(rotor) * longint'(poles), m);
    est.delta   = delta[15:0];
    est.ready   = closed;
    est.raw     = raw_speed;
    est.control = ctl_speed;
    est.display = dsp_speed;
    pending_estimates.push_back(est);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on output beat %0d: %s got 0x%0h, expected 0x%0h",
             out_beats, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dir_neg     = 1'b0;
      delta_lim   = 15'd32767;
      win_ticks   = 16'd100;
      rpm_scale   = 32'd65536;
      ctl_alpha   = 17'd65536;
      dsp_alpha   = 17'd3277;
      counts_rev  = 16'd4000;
      poles       = 7'd4;
      last_count  = '0;
      count_valid = 1'b0;
      rotor       = '0;
      win_sum     = 0;
      win_count   = 0;
      ctl_seeded  = 1'b0;
      dsp_seeded  = 1'b0;
      ctl_speed   = 0;
      dsp_speed   = 0;
      raw_speed   = 0;
      pending_estimates.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_estimates.size() == 0) begin
          report_mismatch("beat with nothing expected", out_tdata[31:0], '0);
        end else begin
          oldest = pending_estimates.pop_front();
          if (out_tdata[15:0] !== oldest.mech)
            report_mismatch("mech_position", out_tdata[15:0], oldest.mech);
          if (out_tdata[31:16] !== oldest.elec)
            report_mismatch("elec_position", out_tdata[31:16], oldest.elec);
          if (out_tdata[47:32] !== oldest.delta)
            report_mismatch("step_delta", out_tdata[47:32], oldest.delta);
          if (out_tuser !== oldest.ready)
            report_mismatch("sample_ready", out_tuser, oldest.ready);
          if (out_tdata[79:48] !== oldest.raw)
            report_mismatch("raw_speed_q8", out_tdata[79:48], oldest.raw);
          if (out_tdata[111:80] !== oldest.control)
            report_mismatch("control_speed_q8", out_tdata[111:80], oldest.control);
          if (out_tdata[143:112] !== oldest.display)
            report_mismatch("display_speed_q8", out_tdata[143:112], oldest.display);
        end
        out_beats++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DIRECTION:      dir_neg    = cfg_data[0];
          CFG_DELTA_LIMIT:    delta_lim  = cfg_data[14:0];
          CFG_WINDOW_TICKS:   win_ticks  = cfg_data[15:0];
          CFG_RPM_SCALE:      rpm_scale  = cfg_data;
          CFG_CONTROL_ALPHA:  ctl_alpha  = cfg_data[16:0];
          CFG_DISPLAY_ALPHA:  dsp_alpha  = cfg_data[16:0];
          CFG_COUNTS_PER_REV: counts_rev = cfg_data[15:0];
          CFG_POLE_PAIRS:     poles      = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_estimate(in_tuser, in_tdata[15:0], in_tdata[32:16]);
    end
    pending = pending_estimates.size();
  end

endmodule

[tb/tb_encoder_position_speed_estimator_top.sv]
// Testbench top for the encoder position / speed estimator: clock, reset,
// directed and random beats, register phases and the verdict.
// Depends on epse_pkg, the block's top level and speed_estimator_checker.
module tb_encoder_position_speed_estimator_top;
  import epse_pkg::*;

  localparam logic CMD_TICK        = 1'b0;
  localparam logic CMD_START       = 1'b1;
  localparam int   PHASES          = 14;
  localparam int   ITEMS_PER_PHASE = 105;
  localparam int   WATCHDOG_LIMIT  = 2000;
  localparam int   TAIL_CYCLES     = 70;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [15:0] timer_count, [32:16] align_offset, [39:33] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [0] command
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [15:0] mech, [31:16] elec, [47:32] delta, [79:48] raw, [111:80] control,
  // [143:112] display
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [0] sample_ready
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          fail_count;
  int          pending;
  int          windows_closed;

  logic        idle_on;
  logic [15:0] enc_count;
  logic [16:0] offset;
  int          n_items;
  int          n_starts;
  int          n_cfg;
  int          p;
  int          k;
  int          kind;
  int          span;
  int          jump;
  int          stall_left;
  int          quiet_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  encoder_position_speed_estimator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  speed_estimator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .windows_closed (windows_closed)
  );

  // receiver back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (idle_on && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 5);
    out_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [15:0] count, logic [16:0] align);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, align, count};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    enc_count = count;
    n_items++;
    if (cmd == CMD_START) n_starts++;
  endtask

  // hold off the sender until every beat in flight has come out
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    n_cfg++;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_on    = 1'b1;
    enc_count  = '0;
    stall_left = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tick before any start with no previous count, wraps, clamp at
    // the half range, offset extremes and count extremes
    send_item(CMD_TICK,  16'h1234, 17'h00000);
    send_item(CMD_TICK,  16'h1250, 17'h1FFFF);
    send_item(CMD_START, 16'h0000, 17'h00000);
    send_item(CMD_TICK,  16'hFFFF, 17'h00000);
    send_item(CMD_TICK,  16'h7FFF, 17'h00000);
    send_item(CMD_TICK,  16'hFFFF, 17'h00000);
    send_item(CMD_TICK,  16'h0000, 17'h00000);
    send_item(CMD_START, 16'hFFFF, 17'h10001);
    send_item(CMD_TICK,  16'hFFFE, 17'h0FFFF);
    send_item(CMD_START, 16'h8000, 17'h0FFFF);
    send_item(CMD_TICK,  16'h8FA0, 17'h00000);
    send_item(CMD_START, 16'h1234, 17'h10000);
    send_item(CMD_TICK,  16'h0234, 17'h00000);
    send_item(CMD_START, 16'h0000, 17'h0FFFF);
    for (k = 0; k < 6; k++)
      send_item(CMD_TICK, enc_count + 16'd1000, 17'h00000);
    for (k = 0; k < 4; k++)
      send_item(CMD_TICK, enc_count - 16'd777, 17'h00000);

    for (p = 1; p < PHASES; p++) begin
      wait_results();
      case (p)
        1: begin  // lowest legal settings
          cfg_write(CFG_DIRECTION, 0);
          cfg_write(CFG_DELTA_LIMIT, 0);
          cfg_write(CFG_WINDOW_TICKS, 1);
          cfg_write(CFG_RPM_SCALE, 0);
          cfg_write(CFG_CONTROL_ALPHA, 0);
          cfg_write(CFG_DISPLAY_ALPHA, 0);
          cfg_write(CFG_COUNTS_PER_REV, 1);
          cfg_write(CFG_POLE_PAIRS, 1);
        end
        2: begin  // highest legal settings
          cfg_write(CFG_DIRECTION, 1);
          cfg_write(CFG_DELTA_LIMIT, 32767);
          cfg_write(CFG_WINDOW_TICKS, 65535);
          cfg_write(CFG_RPM_SCALE, 32'hFFFF_FFFF);
          cfg_write(CFG_CONTROL_ALPHA, 65536);
          cfg_write(CFG_DISPLAY_ALPHA, 65536);
          cfg_write(CFG_COUNTS_PER_REV, 65535);
          cfg_write(CFG_POLE_PAIRS, 64);
        end
        3: begin  // zero modulus, zero window, alpha above one
          cfg_write(CFG_DIRECTION, 0);
          cfg_write(CFG_DELTA_LIMIT, 500);
          cfg_write(CFG_WINDOW_TICKS, 0);
          cfg_write(CFG_RPM_SCALE, 32'h0001_0000);
          cfg_write(CFG_CONTROL_ALPHA, 17'h1FFFF);
          cfg_write(CFG_DISPLAY_ALPHA, 65537);
          cfg_write(CFG_COUNTS_PER_REV, 0);
          cfg_write(CFG_POLE_PAIRS, 127);
        end
        4: begin  // shrink the modulus under a large position, saturate raw speed
          cfg_write(CFG_COUNTS_PER_REV, 7);
          cfg_write(CFG_POLE_PAIRS, 0);
          cfg_write(CFG_WINDOW_TICKS, 2);
          cfg_write(CFG_RPM_SCALE, 32'hFFFF_FFFF);
          cfg_write(CFG_CONTROL_ALPHA, $urandom_range(0, 65536));
          cfg_write(CFG_DISPLAY_ALPHA, $urandom_range(0, 65536));
        end
        default: begin
          if ($urandom_range(0, 1)) cfg_write(CFG_DIRECTION, $urandom_range(0, 1));
          if ($urandom_range(0, 1))
            cfg_write(CFG_DELTA_LIMIT,
                      $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 64));
          if ($urandom_range(0, 3) != 0)
            cfg_write(CFG_WINDOW_TICKS,
                      $urandom_range(0, 7) != 0 ? $urandom_range(0, 12)
                                                : $urandom_range(0, 65535));
          if ($urandom_range(0, 1))
            cfg_write(CFG_RPM_SCALE,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000));
          if ($urandom_range(0, 1)) cfg_write(CFG_CONTROL_ALPHA, $urandom_range(0, 131071));
          if ($urandom_range(0, 1)) cfg_write(CFG_DISPLAY_ALPHA, $urandom_range(0, 70000));
          if ($urandom_range(0, 1))
            cfg_write(CFG_COUNTS_PER_REV,
                      $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(1, 50));
          if ($urandom_range(0, 1)) cfg_write(CFG_POLE_PAIRS, $urandom_range(0, 127));
        end
      endcase
      idle_on <= (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

      // mostly a plausible count trajectory, some starts and raw noise
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        kind   = $urandom_range(0, 99);
        offset = 17'($urandom);
        if (kind < 4) begin
          send_item(CMD_START, 16'($urandom), offset);
        end else if (kind < 10) begin
          send_item(CMD_TICK, 16'($urandom), offset);
        end else begin
          case ($urandom_range(0, 3))
            0:       span = 16;
            1:       span = 600;
            2:       span = 9000;
            default: span = 65535;
          endcase
          jump = int'($urandom_range(0, span)) - span / 2;
          send_item(CMD_TICK, enc_count + 16'(jump), offset);
        end
        if ($urandom_range(0, 199) == 0 || (p == 5 && k == 50))
          wait_results();
      end
    end

    wait_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Drove %0d encoder beats (%0d starts) through %0d register settings, %0d writes.",
             n_items, n_starts, PHASES, n_cfg);
    $display("Speed windows closed: %0d; covered wraps, clamps, modulus changes and filters.",
             windows_closed);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
